[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Word types, opcodes and status codes used by the unit's top-level module.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_SAT  = 2'd1;
	localparam logic [1:0] STATUS_DIV0 = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} op_word_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic [1:0]         status;
	} res_word_t;

endpackage

[rtl/cau_div.sv]
// ----------------------------------------------------------------------------
// Pipelined quotient unit
// Computes (num * 2^FRAC_BITS) / den for unsigned operands, one quotient bit
// per stage, with a flag for quotients that do not fit in WIDTH bits.
// ----------------------------------------------------------------------------
module cau_div #(
	parameter int WIDTH     = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2*WIDTH-1:0]   num,
	input  logic [2*WIDTH-1:0]   den,
	output logic [WIDTH-1:0]     quo,
	output logic                 ovf
);
	localparam int RW = 3 * WIDTH;

	logic [RW-1:0]      rem_q [WIDTH+1];
	logic [2*WIDTH-1:0] den_q [WIDTH+1];
	logic [WIDTH-1:0]   quo_q [WIDTH+1];
	logic               ovf_q [WIDTH+1];

	logic [RW-1:0] n_wide;
	logic [RW-1:0] d_top;

	assign n_wide = RW'(num) << FRAC_BITS;
	assign d_top  = RW'(den) << WIDTH;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= n_wide;
			den_q[0] <= den;
			quo_q[0] <= '0;
			ovf_q[0] <= (n_wide >= d_top);
		end
	end

	for (genvar k = 0; k < WIDTH; k++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(den_q[k]) << (WIDTH - 1 - k);
		assign ge  = (rem_q[k] >= dsh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
				den_q[k+1] <= den_q[k];
				quo_q[k+1] <= quo_q[k] | (ge ? (WIDTH'(1) << (WIDTH - 1 - k)) : '0);
				ovf_q[k+1] <= ovf_q[k];
			end
		end
	end

	assign quo = quo_q[WIDTH];
	assign ovf = ovf_q[WIDTH];

endmodule

[rtl/complex_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply or divide two signed fixed-point complex numbers.
// ----------------------------------------------------------------------------
// The unit accepts one word per clock unless a result-side stall holds it, and
// returns one result word per input word, in order. Every word passes the same
// stages to the output register, whatever the opcode; the depth is set by the
// quotient pipeline, which resolves one quotient bit per stage. A stall on the
// result side holds the whole pipeline without losing or repeating words.
module complex_arithmetic_unit #(
	parameter int WIDTH     = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_stall,
	input  cau_pkg::op_word_t  op_word,
	output logic               res_valid,
	input  logic               res_stall,
	output cau_pkg::res_word_t res_word
);
	import cau_pkg::*;

	localparam int W  = WIDTH;
	localparam int D  = WIDTH + 1;

	logic en;

	// Stage 1: operand capture.
	logic               vld_s1;
	logic [1:0]         op_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// Stage 2: products and sums.
	logic                  vld_s2;
	logic [1:0]            op_s2;
	logic signed [2*W-1:0] prr_s2, pii_s2, pri_s2, pir_s2, sqr_s2, sqi_s2;
	logic signed [W:0]     sre_s2, sim_s2;

	// Stage 3: combined products.
	logic                  vld_s3;
	logic [1:0]            op_s3;
	logic signed [2*W:0]   mre_s3, mim_s3, nre_s3, nim_s3;
	logic [2*W-1:0]        den_s3;
	logic signed [W:0]     sre_s3, sim_s3;

	// Stage 4: non-division results and division operands.
	logic                  vld_s4;
	logic [1:0]            op_s4;
	logic signed [W-1:0]   rre_s4, rim_s4;
	logic                  sat_s4, nre_neg_s4, nim_neg_s4, dz_s4;
	logic [2*W-1:0]        nre_mag_s4, nim_mag_s4, den_s4;

	typedef struct packed {
		logic [1:0]          op;
		logic signed [W-1:0] rre;
		logic signed [W-1:0] rim;
		logic                sat;
		logic                nre_neg;
		logic                nim_neg;
		logic                dz;
	} side_t;

	side_t side_sd [D];
	logic  side_vld_sd [D];

	logic [W-1:0] qre, qim;
	logic         ore, oim;

	logic                res_valid_q;
	res_word_t           res_word_q;

	assign en        = !(res_valid_q && res_stall);
	assign op_stall  = !en;
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	function automatic logic [2*W-1:0] mag2(input logic signed [2*W:0] x);
		logic signed [2*W:0] m;
		m = x[2*W] ? -x : x;
		return m[2*W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= op_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_word.opcode;
			ar_s1 <= op_word.a_re[W-1:0];
			ai_s1 <= op_word.a_im[W-1:0];
			br_s1 <= op_word.b_re[W-1:0];
			bi_s1 <= op_word.b_im[W-1:0];

			op_s2  <= op_s1;
			prr_s2 <= (2*W)'(ar_s1) * (2*W)'(br_s1);
			pii_s2 <= (2*W)'(ai_s1) * (2*W)'(bi_s1);
			pri_s2 <= (2*W)'(ar_s1) * (2*W)'(bi_s1);
			pir_s2 <= (2*W)'(ai_s1) * (2*W)'(br_s1);
			sqr_s2 <= (2*W)'(br_s1) * (2*W)'(br_s1);
			sqi_s2 <= (2*W)'(bi_s1) * (2*W)'(bi_s1);
			if (op_s1 == OP_SUB) begin
				sre_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
				sim_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
			end else begin
				sre_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
				sim_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
			end

			op_s3  <= op_s2;
			mre_s3 <= (2*W+1)'(prr_s2) - (2*W+1)'(pii_s2);
			mim_s3 <= (2*W+1)'(pri_s2) + (2*W+1)'(pir_s2);
			nre_s3 <= (2*W+1)'(prr_s2) + (2*W+1)'(pii_s2);
			nim_s3 <= (2*W+1)'(pir_s2) - (2*W+1)'(pri_s2);
			den_s3 <= sqr_s2 + sqi_s2;
			sre_s3 <= sre_s2;
			sim_s3 <= sim_s2;
		end
	end

	logic signed [2*W:0] max_v, min_v, mre_sh, mim_sh;
	logic signed [W-1:0] c_rre, c_rim;
	logic                c_sat;

	assign max_v  = {{(W+2){1'b0}}, {(W-1){1'b1}}};
	assign min_v  = {{(W+2){1'b1}}, {(W-1){1'b0}}};
	assign mre_sh = mre_s3 >>> FRAC_BITS;
	assign mim_sh = mim_s3 >>> FRAC_BITS;

	always_comb begin
		logic sat_re, sat_im;
		if (op_s3 == OP_MUL) begin
			sat_re = (mre_sh > max_v) || (mre_sh < min_v);
			sat_im = (mim_sh > max_v) || (mim_sh < min_v);
			c_rre  = sat_re ? (mre_sh[2*W] ? min_v[W-1:0] : max_v[W-1:0]) : mre_sh[W-1:0];
			c_rim  = sat_im ? (mim_sh[2*W] ? min_v[W-1:0] : max_v[W-1:0]) : mim_sh[W-1:0];
		end else begin
			sat_re = (sre_s3[W] != sre_s3[W-1]);
			sat_im = (sim_s3[W] != sim_s3[W-1]);
			c_rre  = sat_re ? (sre_s3[W] ? min_v[W-1:0] : max_v[W-1:0]) : sre_s3[W-1:0];
			c_rim  = sat_im ? (sim_s3[W] ? min_v[W-1:0] : max_v[W-1:0]) : sim_s3[W-1:0];
		end
		c_sat = sat_re || sat_im;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4      <= op_s3;
			rre_s4     <= c_rre;
			rim_s4     <= c_rim;
			sat_s4     <= c_sat;
			nre_neg_s4 <= nre_s3[2*W];
			nim_neg_s4 <= nim_s3[2*W];
			nre_mag_s4 <= mag2(nre_s3);
			nim_mag_s4 <= mag2(nim_s3);
			den_s4     <= den_s3;
			dz_s4      <= (den_s3 == '0);
		end
	end

	cau_div #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk (clk),
		.en  (en),
		.num (nre_mag_s4),
		.den (den_s4),
		.quo (qre),
		.ovf (ore)
	);

	cau_div #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk (clk),
		.en  (en),
		.num (nim_mag_s4),
		.den (den_s4),
		.quo (qim),
		.ovf (oim)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < D; k++) begin
				side_vld_sd[k] <= 1'b0;
			end
		end else if (en) begin
			side_vld_sd[0] <= vld_s4;
			for (int k = 1; k < D; k++) begin
				side_vld_sd[k] <= side_vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0].op      <= op_s4;
			side_sd[0].rre     <= rre_s4;
			side_sd[0].rim     <= rim_s4;
			side_sd[0].sat     <= sat_s4;
			side_sd[0].nre_neg <= nre_neg_s4;
			side_sd[0].nim_neg <= nim_neg_s4;
			side_sd[0].dz      <= dz_s4;
			for (int k = 1; k < D; k++) begin
				side_sd[k].op      <= side_sd[k-1].op;
				side_sd[k].rre     <= side_sd[k-1].rre;
				side_sd[k].rim     <= side_sd[k-1].rim;
				side_sd[k].sat     <= side_sd[k-1].sat;
				side_sd[k].nre_neg <= side_sd[k-1].nre_neg;
				side_sd[k].nim_neg <= side_sd[k-1].nim_neg;
				side_sd[k].dz      <= side_sd[k-1].dz;
			end
		end
	end

	side_t               sl;
	logic signed [W-1:0] f_re, f_im;
	logic [1:0]          f_status;

	assign sl = side_sd[D-1];

	always_comb begin
		logic dsat_re, dsat_im;
		logic [W-1:0] lim;
		lim = {1'b1, {(W-1){1'b0}}};
		if (sl.nre_neg) begin
			dsat_re = ore || (qre > lim);
			f_re    = dsat_re ? lim : -qre;
		end else begin
			dsat_re = ore || qre[W-1];
			f_re    = dsat_re ? ~lim : qre;
		end
		if (sl.nim_neg) begin
			dsat_im = oim || (qim > lim);
			f_im    = dsat_im ? lim : -qim;
		end else begin
			dsat_im = oim || qim[W-1];
			f_im    = dsat_im ? ~lim : qim;
		end
		if (sl.op != OP_DIV) begin
			f_re     = sl.rre;
			f_im     = sl.rim;
			f_status = sl.sat ? STATUS_SAT : STATUS_OK;
		end else if (sl.dz) begin
			f_re     = '0;
			f_im     = '0;
			f_status = STATUS_DIV0;
		end else begin
			f_status = (dsat_re || dsat_im) ? STATUS_SAT : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= side_vld_sd[D-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_word_q.res_re <= 32'(f_re);
			res_word_q.res_im <= 32'(f_im);
			res_word_q.status <= f_status;
		end
	end

endmodule
